/* hdl/csts_pkg.sv */
// ---------------------------------------------------------------------------
// Cubic segment sampler package
// Shared constants, value type and saturation helper.
// ---------------------------------------------------------------------------
package csts_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam logic [15:0] SI_RESET = 16'd50;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    // Clamp a 64-bit signed value into the signed output range.
    function automatic t_value sat_value(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[VALUE_WIDTH-1:0];
        end else if (v < lo) begin
            return lo[VALUE_WIDTH-1:0];
        end
        return v[VALUE_WIDTH-1:0];
    endfunction

endpackage

/* hdl/cubic_segment_trajectory_sampler_unit.sv */
// ---------------------------------------------------------------------------
// Cubic segment trajectory sampler
// Fits a cubic Hermite segment per axis and emits position, velocity and
// acceleration samples in Q16.16 at multiples of the sample interval and at the end.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_stall   | axis, positions, vels, T
//  out      | output    | o_out_valid / i_out_stall | tag, time, p, v, a, flags
//  cfg      | input     | i_cfg_we                  | sample interval
//
// Setup runs through the K2, K3, KT and KTF states; each sample then runs the
// serial divider three times (time, velocity, acceleration) plus the shared
// multiplier steps. A zero duration gives one word in the cycle after the
// segment is accepted.
// Reset is synchronous; the interval register returns to 50.
// An output stall holds the word and freezes the sequencer until taken.
// ---------------------------------------------------------------------------
module cubic_segment_trajectory_sampler_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [15:0]                      i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_axis_id,
    input  logic signed [31:0]               i_start_pos,
    input  logic signed [31:0]               i_start_vel,
    input  logic signed [31:0]               i_end_pos,
    input  logic signed [31:0]               i_end_vel,
    input  logic [15:0]                      i_duration_ticks,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_axis_tag,
    output logic [15:0]                      o_sample_time,
    output logic signed [csts_pkg::VALUE_WIDTH-1:0] o_position,
    output logic signed [csts_pkg::VALUE_WIDTH-1:0] o_velocity,
    output logic signed [csts_pkg::VALUE_WIDTH-1:0] o_acceleration,
    output logic                             o_last_sample,
    output logic                             o_truncated
);
    import csts_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_K2   = 5'd1;
    localparam logic [4:0] ST_K3   = 5'd2;
    localparam logic [4:0] ST_KT   = 5'd3;
    localparam logic [4:0] ST_KTF  = 5'd4;
    localparam logic [4:0] ST_SAMP = 5'd5;
    localparam logic [4:0] ST_UGO  = 5'd6;
    localparam logic [4:0] ST_UWT  = 5'd7;
    localparam logic [4:0] ST_MUU  = 5'd8;
    localparam logic [4:0] ST_MU2  = 5'd9;
    localparam logic [4:0] ST_MU3  = 5'd10;
    localparam logic [4:0] ST_MVT  = 5'd11;
    localparam logic [4:0] ST_MQH  = 5'd12;
    localparam logic [4:0] ST_MQL  = 5'd13;
    localparam logic [4:0] ST_MQF  = 5'd14;
    localparam logic [4:0] ST_VGO  = 5'd15;
    localparam logic [4:0] ST_VWT  = 5'd16;
    localparam logic [4:0] ST_AGO  = 5'd17;
    localparam logic [4:0] ST_AWT  = 5'd18;
    localparam logic [4:0] ST_OUT  = 5'd19;

    // Scaled products taken in turn: which coefficient, which power of u.
    localparam logic [2:0] MQ_C2U2 = 3'd0;
    localparam logic [2:0] MQ_C3U3 = 3'd1;
    localparam logic [2:0] MQ_C2U  = 3'd2;
    localparam logic [2:0] MQ_C3U2 = 3'd3;
    localparam logic [2:0] MQ_C3U  = 3'd4;

    logic [4:0]         r_state;
    logic [15:0]        r_interval;
    logic [1:0]         r_axis;
    logic signed [31:0] r_p0, r_v0, r_pf, r_vf;
    logic [15:0]        r_T;
    logic [15:0]        r_dt;
    logic [16:0]        r_t;
    logic [IDX_W-1:0]   r_idx;
    logic [15:0]        r_ts;
    logic               r_last, r_trunc;
    logic signed [63:0] r_c2, r_c3;
    logic [31:0]        r_tt;
    logic [31:0]        r_u, r_u2, r_u3;
    logic signed [63:0] r_pacc, r_w, r_an;
    logic [63:0]        r_mq;
    logic [2:0]         r_mq_id;
    logic signed [67:0] r_prod;
    t_value             r_o_pos, r_o_vel, r_o_acc;

    logic signed [34:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [63:0] w_d;
    logic signed [63:0] w_coef;
    logic [63:0]        w_mag;
    logic [31:0]        w_x;
    logic [63:0]        w_r;
    logic signed [63:0] w_sres;
    logic               w_div_start;
    logic signed [63:0] w_div_num;
    logic [31:0]        w_div_den;
    logic               w_div_done;
    logic signed [63:0] w_div_q;

    assign w_d = 64'(r_pf) - 64'(r_p0);

    // Operand selection for the scaled coefficient products.
    always_comb begin
        case (r_mq_id)
            MQ_C2U2: begin w_coef = r_c2; w_x = r_u2; end
            MQ_C3U3: begin w_coef = r_c3; w_x = r_u3; end
            MQ_C2U:  begin w_coef = r_c2; w_x = r_u;  end
            MQ_C3U2: begin w_coef = r_c3; w_x = r_u2; end
            default: begin w_coef = r_c3; w_x = r_u;  end
        endcase
        w_mag  = w_coef[63] ? 64'(-w_coef) : 64'(w_coef);
        w_r    = r_mq + {31'd0, r_prod[63:31]};
        w_sres = w_coef[63] ? -$signed(w_r) : $signed(w_r);
    end

    // Shared multiplier operands, chosen by the sequencer state.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_K2: begin
                w_mul_a = 35'(r_v0) + 35'(r_v0) + 35'(r_vf);
                w_mul_b = $signed({17'd0, r_T});
            end
            ST_K3: begin
                w_mul_a = 35'(r_v0) + 35'(r_vf);
                w_mul_b = $signed({17'd0, r_T});
            end
            ST_KT: begin
                w_mul_a = $signed({19'd0, r_T});
                w_mul_b = $signed({17'd0, r_T});
            end
            ST_MUU: begin
                w_mul_a = $signed({3'd0, r_u});
                w_mul_b = $signed({1'b0, r_u});
            end
            ST_MU2: begin
                w_mul_a = $signed({3'd0, r_prod[62:31]});
                w_mul_b = $signed({1'b0, r_u});
            end
            ST_MU3: begin
                w_mul_a = 35'(r_v0);
                w_mul_b = $signed({17'd0, r_ts});
            end
            ST_MQH: begin
                w_mul_a = $signed({3'd0, w_mag[63:32]});
                w_mul_b = $signed({1'b0, w_x});
            end
            ST_MQL: begin
                w_mul_a = $signed({3'd0, w_mag[31:0]});
                w_mul_b = $signed({1'b0, w_x});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Registered product.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // Divider requests: normalized time, velocity term, acceleration term.
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = r_w;
        w_div_den   = {16'd0, r_T};
        case (r_state)
            ST_UGO: begin
                w_div_start = 1'b1;
                w_div_num   = $signed({17'd0, r_ts, 31'd0});
            end
            ST_VGO: begin
                w_div_start = 1'b1;
                w_div_num   = r_w;
            end
            ST_AGO: begin
                w_div_start = 1'b1;
                w_div_num   = r_an;
                w_div_den   = r_tt;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    csts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // Interval register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= SI_RESET;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= (i_duration_ticks == 16'd0) ? ST_OUT : ST_K2;
                    end
                end
                ST_K2:   r_state <= ST_K3;
                ST_K3:   r_state <= ST_KT;
                ST_KT:   r_state <= ST_KTF;
                ST_KTF:  r_state <= ST_SAMP;
                ST_SAMP: r_state <= ST_UGO;
                ST_UGO:  r_state <= ST_UWT;
                ST_UWT:  r_state <= w_div_done ? ST_MUU : ST_UWT;
                ST_MUU:  r_state <= ST_MU2;
                ST_MU2:  r_state <= ST_MU3;
                ST_MU3:  r_state <= ST_MVT;
                ST_MVT:  r_state <= ST_MQH;
                ST_MQH:  r_state <= ST_MQL;
                ST_MQL:  r_state <= ST_MQF;
                ST_MQF: begin
                    case (r_mq_id)
                        MQ_C3U2: r_state <= ST_VGO;
                        MQ_C3U:  r_state <= ST_AGO;
                        default: r_state <= ST_MQH;
                    endcase
                end
                ST_VGO:  r_state <= ST_VWT;
                ST_VWT:  r_state <= w_div_done ? ST_MQH : ST_VWT;
                ST_AGO:  r_state <= ST_AWT;
                ST_AWT:  r_state <= w_div_done ? ST_OUT : ST_AWT;
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= r_last ? ST_IDLE : ST_SAMP;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers: coefficients, powers of u, sums and results.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_axis  <= i_axis_id;
                r_p0    <= i_start_pos;
                r_v0    <= i_start_vel;
                r_pf    <= i_end_pos;
                r_vf    <= i_end_vel;
                r_T     <= i_duration_ticks;
                r_dt    <= (r_interval == 16'd0) ? 16'd1 : r_interval;
                r_t     <= '0;
                r_idx   <= '0;
                // A zero-duration segment emits its end point at once.
                r_ts    <= '0;
                r_last  <= 1'b1;
                r_trunc <= 1'b0;
                r_o_pos <= sat_value(64'(i_end_pos));
                r_o_vel <= sat_value(64'(i_end_vel));
                r_o_acc <= '0;
            end
            ST_K3: r_c2 <= w_d + w_d + w_d - $signed(r_prod[63:0]);
            ST_KT: r_c3 <= $signed(r_prod[63:0]) - w_d - w_d;
            ST_KTF: r_tt <= r_prod[31:0];
            ST_SAMP: begin
                if (r_t >= {1'b0, r_T}) begin
                    r_ts    <= r_T;
                    r_last  <= 1'b1;
                    r_trunc <= 1'b0;
                end else begin
                    r_ts    <= r_t[15:0];
                    r_last  <= (r_idx == IDX_W'(MAX_SAMPLES - 1));
                    r_trunc <= (r_idx == IDX_W'(MAX_SAMPLES - 1));
                end
            end
            ST_UWT: begin
                if (w_div_done) begin
                    r_u <= w_div_q[31:0];
                end
            end
            ST_MU2: r_u2 <= r_prod[62:31];
            ST_MU3: r_u3 <= r_prod[62:31];
            ST_MVT: begin
                r_pacc  <= 64'(r_p0) + $signed(r_prod[63:0]);
                r_mq_id <= MQ_C2U2;
            end
            ST_MQL: r_mq <= {r_prod[62:0], 1'b0};
            ST_MQF: begin
                case (r_mq_id)
                    MQ_C2U2: begin
                        r_pacc  <= r_pacc + w_sres;
                        r_mq_id <= MQ_C3U3;
                    end
                    MQ_C3U3: begin
                        r_o_pos <= sat_value(r_pacc + w_sres);
                        r_mq_id <= MQ_C2U;
                    end
                    MQ_C2U: begin
                        r_w     <= w_sres + w_sres;
                        r_mq_id <= MQ_C3U2;
                    end
                    MQ_C3U2: begin
                        r_w <= r_w + w_sres + w_sres + w_sres;
                    end
                    default: begin
                        r_an <= r_c2 + r_c2 + w_sres + w_sres + w_sres
                              + w_sres + w_sres + w_sres;
                    end
                endcase
            end
            ST_VWT: begin
                if (w_div_done) begin
                    r_o_vel <= sat_value(64'(r_v0) + w_div_q);
                    r_mq_id <= MQ_C3U;
                end
            end
            ST_AWT: begin
                if (w_div_done) begin
                    r_o_acc <= sat_value(w_div_q);
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    r_t   <= r_t + {1'b0, r_dt};
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
                r_mq <= r_mq;
            end
        endcase
    end

    // Ports.
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = (r_state == ST_OUT);
    assign o_axis_tag     = r_axis;
    assign o_sample_time  = r_ts;
    assign o_position     = r_o_pos;
    assign o_velocity     = r_o_vel;
    assign o_acceleration = r_o_acc;
    assign o_last_sample  = r_last;
    assign o_truncated    = r_trunc;

endmodule

/* hdl/csts_div.sv */
// ---------------------------------------------------------------------------
// Serial signed divider
// Radix-2 restoring division of a signed 64-bit dividend by a positive
// 32-bit divisor, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module csts_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic        [31:0] i_divisor,
    output logic               o_done,
    output logic signed [63:0] o_quotient
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic        r_done;
    logic [32:0] w_rem_sh;
    logic [32:0] w_rem_sub;
    logic        w_bit;

    // One restoring step on the shifted partial remainder.
    always_comb begin
        w_rem_sh  = {r_rem, r_quo[63]};
        w_rem_sub = w_rem_sh - {1'b0, r_dvs};
        w_bit     = (w_rem_sh >= {1'b0, r_dvs});
    end

    // Control: busy flag, step counter and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude in the quotient register, remainder beside it.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[63];
            r_quo <= i_dividend[63] ? 64'(-i_dividend) : 64'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_rem_sub[31:0] : w_rem_sh[31:0];
            r_quo <= {r_quo[62:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

/* hdl/csts_chk.sv */
// ---------------------------------------------------------------------------
// Cubic segment sampler port checker
// Watches the top-level ports over time and flags handshake or flag slips.
// ---------------------------------------------------------------------------
module csts_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic signed [csts_pkg::VALUE_WIDTH-1:0] o_position,
    input logic                             o_last_sample,
    input logic                             o_truncated
);
    // A stalled word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_position))
        else $error("output word dropped under stall");

    // The truncation flag only appears on the final word.
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_last_sample)
        else $error("truncated without last sample");

    // An accepted segment blocks the input on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice in a row");

    // No word is offered while the block waits for a segment.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("output valid while idle");

endmodule

bind cubic_segment_trajectory_sampler_unit csts_chk u_csts_chk (.*);

/* verif/cubic_segment_trajectory_sampler_unit_chk.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Cubic segment sampler checker
// Watches the config, input and output channels, predicts every sample word
// of each accepted segment and compares the output words in order.
// ---------------------------------------------------------------------------
module cubic_segment_trajectory_sampler_unit_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_axis_id,
    input  logic signed [31:0] i_start_pos,
    input  logic signed [31:0] i_start_vel,
    input  logic signed [31:0] i_end_pos,
    input  logic signed [31:0] i_end_vel,
    input  logic [15:0]        i_duration_ticks,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_axis_tag,
    input  logic [15:0]        i_sample_time,
    input  csts_pkg::t_value   i_position,
    input  csts_pkg::t_value   i_velocity,
    input  csts_pkg::t_value   i_acceleration,
    input  logic               i_last_sample,
    input  logic               i_truncated,
    output int                 o_fail_count,
    output int                 o_pending
);
    import csts_pkg::*;

    typedef struct {
        logic [1:0]  tag;
        logic [15:0] stime;
        t_value      pos;
        t_value      vel;
        t_value      acc;
        logic        last;
        logic        trunc;
    } t_sample_word;

    t_sample_word samples_due[$];
    logic [15:0]  interval_q;
    int           mismatch_count;

    assign o_fail_count = mismatch_count;

    // Clamp to the signed output range.
    function automatic t_value clamp_q(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
        end else if (v < lo) begin
            v = lo;
        end
        return t_value'(v);
    endfunction

    // Coefficient times a Q1.31 fraction, truncated toward zero.
    function automatic longint scale_q31(input longint c, input longint unsigned x);
        bit                neg;
        longint unsigned   mag;
        longint unsigned   r;
        neg = c < 0;
        mag = neg ? longint'(-c) : c;
        r   = (((mag >> 32) * x) << 1) + (((mag & 64'hFFFF_FFFF) * x) >> 31);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Queue every sample word that one segment produces.
    task automatic predict_segment(input logic [1:0] axis, input logic signed [31:0] sp,
                                   input logic signed [31:0] sv, input logic signed [31:0] ep,
                                   input logic signed [31:0] ev, input logic [15:0] dur);
        longint          p0, v0, ti, tt, d, c2, c3, ts, p, w;
        longint unsigned tu, dt, cnt, n, t, u, u2, u3, i;
        bit              cut;
        bit              last;
        t_sample_word    s;
        p0 = sp;
        v0 = sv;
        tu = dur;
        if (dur == 0) begin
            s = '{axis, 16'd0, clamp_q(ep), clamp_q(ev), clamp_q(0), 1'b1, 1'b0};
            samples_due = {samples_due, s};
            return;
        end
        dt  = (interval_q == 0) ? 1 : interval_q;
        cnt = (tu + dt - 1) / dt + 1;
        cut = cnt > MAX_SAMPLES;
        n   = cut ? MAX_SAMPLES : cnt;
        ti  = longint'(tu);
        tt  = ti * ti;
        d   = longint'(ep) - p0;
        c2  = 3 * d - (2 * v0 + longint'(ev)) * ti;
        c3  = -2 * d + (v0 + longint'(ev)) * ti;
        for (i = 0; i < n; i++) begin
            last = (i + 1 == n);
            t    = (last && !cut) ? tu : i * dt;
            u    = (t << 31) / tu;
            u2   = (u * u) >> 31;
            u3   = (u2 * u) >> 31;
            ts   = longint'(t);
            p    = p0 + v0 * ts + scale_q31(c2, u2) + scale_q31(c3, u3);
            w    = 2 * scale_q31(c2, u) + 3 * scale_q31(c3, u2);
            s    = '{axis, t[15:0], clamp_q(p), clamp_q(v0 + w / ti),
                     clamp_q((2 * c2 + 6 * scale_q31(c3, u)) / tt), last, last && cut};
            samples_due = {samples_due, s};
        end
    endtask

    // Track the interval register, predict on input, compare on output.
    always @(posedge i_clk) begin
        t_sample_word e;
        if (!i_rst_n) begin
            interval_q = SI_RESET;
            samples_due.delete();
            mismatch_count = 0;
        end else begin
            // The block latches the interval held before this edge.
            if (i_in_valid && !i_in_stall) begin
                predict_segment(i_axis_id, i_start_pos, i_start_vel, i_end_pos,
                                i_end_vel, i_duration_ticks);
            end
            if (i_cfg_we) begin
                interval_q = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                if (samples_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected output word: t=%0d p=%0d", i_sample_time,
                                 i_position);
                    end
                end else begin
                    e = samples_due.pop_front();
                    if (i_axis_tag !== e.tag || i_sample_time !== e.stime ||
                        i_position !== e.pos || i_velocity !== e.vel ||
                        i_acceleration !== e.acc || i_last_sample !== e.last ||
                        i_truncated !== e.trunc) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch exp: tag=%0d t=%0d p=%0d v=%0d a=%0d l=%0b tr=%0b",
                                     e.tag, e.stime, e.pos, e.vel, e.acc, e.last, e.trunc);
                            $display("         act: tag=%0d t=%0d p=%0d v=%0d a=%0d l=%0b tr=%0b",
                                     i_axis_tag, i_sample_time, i_position, i_velocity,
                                     i_acceleration, i_last_sample, i_truncated);
                        end
                    end
                end
            end
        end
        o_pending = samples_due.size();
    end

endmodule

/* verif/cubic_segment_trajectory_sampler_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Cubic segment sampler testbench
// Drives directed and random segments under several sample intervals, with
// random gaps on the input and random stalls on the output; the checker
// predicts and compares every sample word.
// ---------------------------------------------------------------------------
module cubic_segment_trajectory_sampler_unit_tb;
    import csts_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [15:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_axis_id = '0;
    logic signed [31:0] i_start_pos = '0;
    logic signed [31:0] i_start_vel = '0;
    logic signed [31:0] i_end_pos = '0;
    logic signed [31:0] i_end_vel = '0;
    logic [15:0]        i_duration_ticks = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_axis_tag;
    logic [15:0]        o_sample_time;
    t_value             o_position;
    t_value             o_velocity;
    t_value             o_acceleration;
    logic               o_last_sample;
    logic               o_truncated;
    int                 fail_count;
    int                 pending;
    int                 out_hold = 0;
    bit                 calm_out = 0;
    int                 idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    cubic_segment_trajectory_sampler_unit u_dut (.*);

    cubic_segment_trajectory_sampler_unit_chk u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_in_valid, .i_in_stall(o_in_stall),
        .i_axis_id, .i_start_pos, .i_start_vel, .i_end_pos, .i_end_vel, .i_duration_ticks,
        .i_out_valid(o_out_valid), .i_out_stall, .i_axis_tag(o_axis_tag),
        .i_sample_time(o_sample_time), .i_position(o_position), .i_velocity(o_velocity),
        .i_acceleration(o_acceleration), .i_last_sample(o_last_sample),
        .i_truncated(o_truncated), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: after each taken word, stall for a random number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_hold = calm_out ? 0 : $urandom_range(0, 4);
        end
    end

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall = 1'b1;
            out_hold--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Random Q16.16 value: full range, small, or extreme.
    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2, 3: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        endcase
    endfunction

    // Send one segment word with a random lead-in gap.
    task automatic send_segment(input logic [1:0] axis, input logic signed [31:0] sp,
                                input logic signed [31:0] sv, input logic signed [31:0] ep,
                                input logic signed [31:0] ev, input logic [15:0] dur);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(negedge i_clk);
        i_axis_id        = axis;
        i_start_pos      = sp;
        i_start_vel      = sv;
        i_end_pos        = ep;
        i_end_vel        = ev;
        i_duration_ticks = dur;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Let every outstanding sample drain, then write the interval.
    task automatic set_interval(input logic [15:0] value);
        wait (pending == 0);
        repeat (20) @(negedge i_clk);
        i_cfg_wdata = value;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic random_phase(input int count, input int max_dur);
        for (int k = 0; k < count; k++) begin
            calm_out = (k / 20) % 3 == 2;
            send_segment(2'($urandom_range(0, 3)), rand_q(), rand_q(), rand_q(), rand_q(),
                         ($urandom_range(0, 15) == 0) ? 16'd0
                                                      : 16'($urandom_range(0, max_dur)));
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed segments at the reset interval of 50.
        send_segment(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_segment(1, 0, 0, 32'sh0001_0000, 0, 0);
        send_segment(2, 0, 0, 32'sh0001_0000, 0, 1);
        send_segment(3, 32'sh0010_0000, 32'sh0000_1000, 32'shFFF0_0000, 0, 50);
        send_segment(0, 0, 32'sh0000_8000, 32'sh0040_0000, 32'shFFFF_8000, 51);
        send_segment(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 100);
        send_segment(2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 2);
        send_segment(3, 32'sh0100_0000, 32'shFFFF_0000, 32'sh0200_0000, 32'sh0001_0000, 3150);
        send_segment(0, 32'sh0100_0000, 32'shFFFF_0000, 32'sh0200_0000, 32'sh0001_0000, 3151);
        send_segment(1, 0, 0, 0, 0, 16'hFFFF);
        send_segment(2, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 49);
        random_phase(40, 250);

        set_interval(16'd1);
        send_segment(3, 32'sh0001_0000, 0, 32'sh0002_0000, 0, 63);
        send_segment(0, 32'sh0001_0000, 0, 32'sh0002_0000, 0, 64);
        random_phase(55, 12);

        set_interval(16'hFFFF);
        send_segment(1, 32'sh1234_5678, 32'shFEDC_BA98, 32'sh8765_4321, 32'sh0123_4567, 16'hFFFF);
        random_phase(60, 65535);

        set_interval(16'd0);
        send_segment(2, 0, 32'sh0001_0000, 32'sh0004_0000, 0, 64);
        random_phase(50, 10);

        set_interval(16'd1000);
        random_phase(60, 9000);

        set_interval(16'd7);
        random_phase(45, 80);

        wait (pending == 0);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/csts_pkg.sv
hdl/csts_div.sv
hdl/cubic_segment_trajectory_sampler_unit.sv
hdl/csts_chk.sv
verif/cubic_segment_trajectory_sampler_unit_chk.sv
verif/cubic_segment_trajectory_sampler_unit_tb.sv
